FILE: sv/avca_pkg.sv
`default_nettype none
package avca_pkg;
    typedef enum logic [2:0] {
        CMD_PLAY = 3'd0, CMD_REPLAY = 3'd1, CMD_PAUSE = 3'd2, CMD_RESUME = 3'd3,
        CMD_HALT = 3'd4, CMD_VOLUME = 3'd5, CMD_TICK = 3'd6, CMD_CLEAR = 3'd7
    } cmd_t;
    typedef enum logic [2:0] {
        ACT_START = 3'd0, ACT_VOLUME = 3'd1, ACT_PAUSE = 3'd2, ACT_RESUME = 3'd3,
        ACT_HALT = 3'd4
    } action_t;
    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_WRITE, ST_MIX, ST_EMIT, ST_CLEAR
    } state_t;
    localparam int unsigned REG_MASTER = 0;
    localparam int unsigned REG_MASK = 1;
    localparam int unsigned TIME_W = 28;
    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] key;
        logic [15:0] sound_id;
        logic [19:0] sound_length;
        logic [7:0]  loops;
        logic [6:0]  volume;
        logic [15:0] elapsed;
    } cmd_beat_t;
    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  channel;
        logic [15:0] out_sound;
        logic [7:0]  out_loops;
        logic [7:0]  mixer_vol;
        logic        last;
    } res_beat_t;
    typedef struct packed {
        logic        busy;
        logic        paused;
        logic [63:0] key;
        logic [TIME_W-1:0] time_left;
    } entry_t;
endpackage
`default_nettype wire

FILE: sv/avca_if.sv
`default_nettype none
interface avca_if #(parameter int unsigned W = 1);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/avca_table.sv
`default_nettype none
module avca_table #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW = 6
) (
    input  wire logic clk,
    input  wire logic we,
    input  wire logic [AW-1:0] waddr,
    input  wire avca_pkg::entry_t wdata,
    input  wire logic [AW-1:0] raddr,
    output avca_pkg::entry_t rdata
);
    import avca_pkg::*;
    entry_t mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/audio_voice_channel_allocator_top.sv
// channel  dir  beat
// cmd_in   in   cmd, key, sound_id, sound_length, loops, volume, elapsed
// res_out  out  action, channel, out_sound, out_loops, mixer_vol, last
// cfg      in   APB, master_volume @0x0, reserved_mask @0x8
// Every command but clear scans the table memory, one read port, one entry
// a cycle; on a hit, all but a tick then go through write, multiply and emit.
// Clear reads and writes back each entry: N beats, one per entry.
// After reset a clearing pass writes every entry; no command is taken
// until it ends. A waiting result blocks the next command and holds clear.
`default_nettype none
module audio_voice_channel_allocator_top #(
    parameter int unsigned NUM_CHANNELS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    avca_if.sink   cmd_in,
    avca_if.source res_out,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [3:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic pready
);
    import avca_pkg::*;
    localparam int unsigned NCH = NUM_CHANNELS < 64 ? NUM_CHANNELS : 64;
    localparam int unsigned AW = $clog2(NCH);
    localparam int unsigned CW = AW + 1;
    localparam logic [AW-1:0] LASTCH = AW'(NCH - 1);
    // floor(x * 128 / 10000) == (x * 859000) >> 26 for x up to 10000
    localparam logic [19:0] MIX_RECIP = 20'd859000;

    logic [6:0] master_reg;
    logic [63:0] mask_reg;
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr[3])
            1'b0: prdata = {57'd0, master_reg};
            default: prdata = mask_reg;
        endcase
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg <= 7'd100;
            mask_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == 1'b0)
            begin
                master_reg <= (pwdata[6:0] > 7'd100) ? 7'd100 : pwdata[6:0];
            end
            else
            begin
                mask_reg <= pwdata;
            end
        end
    end

    state_t state_reg, state_next;
    cmd_beat_t cb_reg, cb_next;
    logic [CW-1:0] ra_reg, ra_next;     // read address issued
    logic [CW-1:0] rc_reg, rc_next;     // entry being examined
    logic rv_reg, rv_next;
    logic hit_reg, hit_next;
    logic [AW-1:0] ch_reg, ch_next;
    logic init_reg, init_next;
    res_beat_t res_reg, res_next;
    logic ov_reg, ov_next;
    logic [33:0] prod_reg, prod_next;
    logic we;
    logic [AW-1:0] waddr, raddr;
    entry_t wdata, rdata;

    avca_table #(.DEPTH(NCH), .AW(AW)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );
    assign raddr = ra_reg[AW-1:0];

    logic freech, keym, tick_hit;
    logic [TIME_W-1:0] tl_sub;
    logic [TIME_W-1:0] tl_prod;
    logic [13:0] vm;
    always_comb
    begin
        freech = !rdata.busy && !mask_reg[rc_reg[AW-1:0]];
        keym = rdata.key == cb_reg.key;
        tick_hit = rdata.busy && !rdata.paused;
        tl_sub = (rdata.time_left > TIME_W'(cb_reg.elapsed))
            ? rdata.time_left - TIME_W'(cb_reg.elapsed) : '0;
        tl_prod = TIME_W'(29'(cb_reg.sound_length)
            * 29'({1'b0, cb_reg.loops} + 9'd1));
        vm = {7'd0, ((cb_reg.volume > 7'd100) ? 7'd100 : cb_reg.volume)}
            * {7'd0, master_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        cb_next = cb_reg;
        ra_next = ra_reg;
        rc_next = rc_reg;
        rv_next = 1'b0;
        hit_next = hit_reg;
        ch_next = ch_reg;
        init_next = init_reg;
        res_next = res_reg;
        ov_next = ov_reg;
        prod_next = prod_reg;
        we = 1'b0;
        waddr = rc_reg[AW-1:0];
        wdata = rdata;
        cmd_in.ready = 1'b0;
        if (ov_reg && res_out.ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (init_reg)
                begin
                    we = 1'b1;
                    waddr = ra_reg[AW-1:0];
                    wdata = '0;
                    ra_next = ra_reg + CW'(1);
                    if (ra_reg[AW-1:0] == LASTCH)
                    begin
                        init_next = 1'b0;
                        ra_next = '0;
                    end
                end
                else
                begin
                    cmd_in.ready = !ov_reg;
                    if (cmd_in.valid && !ov_reg)
                    begin
                        cb_next = cmd_in.data;
                        hit_next = 1'b0;
                        rc_next = '0;
                        rv_next = 1'b1;
                        state_next = (cb_next.cmd == CMD_CLEAR) ? ST_CLEAR : ST_SCAN;
                        ra_next = (cb_next.cmd == CMD_CLEAR) ? '0 : CW'(1);
                    end
                end
            end
            ST_SCAN:
            begin
                if (rv_reg)
                begin
                    rc_next = rc_reg + CW'(1);
                    if (ra_reg < CW'(NCH))
                    begin
                        ra_next = ra_reg + CW'(1);
                        rv_next = 1'b1;
                    end
                    case (cb_reg.cmd)
                        CMD_PLAY:
                        begin
                            if (freech)
                            begin
                                hit_next = 1'b1;
                                ch_next = rc_reg[AW-1:0];
                                state_next = ST_WRITE;
                                rv_next = 1'b0;
                            end
                        end
                        CMD_REPLAY:
                        begin
                            if (keym || freech)
                            begin
                                hit_next = 1'b1;
                                ch_next = rc_reg[AW-1:0];
                            end
                            if (keym)
                            begin
                                state_next = ST_WRITE;
                                rv_next = 1'b0;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (tick_hit)
                            begin
                                we = 1'b1;
                                wdata.time_left = tl_sub;
                                if (tl_sub == '0)
                                begin
                                    wdata.busy = 1'b0;
                                    wdata.paused = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            if (rdata.busy && keym)
                            begin
                                hit_next = 1'b1;
                                ch_next = rc_reg[AW-1:0];
                                rv_next = 1'b0;
                                state_next = ST_WRITE;
                                we = cb_reg.cmd != CMD_VOLUME;
                                wdata.paused = cb_reg.cmd == CMD_PAUSE;
                                if (cb_reg.cmd == CMD_HALT)
                                begin
                                    wdata.busy = 1'b0;
                                end
                            end
                        end
                    endcase
                    if (rc_reg[AW-1:0] == LASTCH && state_next == ST_SCAN)
                    begin
                        rv_next = 1'b0;
                        ra_next = '0;
                        state_next = (hit_next && cb_reg.cmd != CMD_TICK)
                            ? ST_WRITE : ST_IDLE;
                    end
                end
            end
            ST_WRITE:
            begin
                ra_next = '0;
                if (cb_reg.cmd == CMD_PLAY || cb_reg.cmd == CMD_REPLAY)
                begin
                    we = 1'b1;
                    waddr = ch_reg;
                    wdata.busy = 1'b1;
                    wdata.paused = 1'b0;
                    wdata.key = cb_reg.key;
                    wdata.time_left = tl_prod;
                end
                prod_next = {20'd0, vm} * {14'd0, MIX_RECIP};
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!ov_next)
                begin
                    ov_next = 1'b1;
                    res_next = '0;
                    res_next.channel = 6'(ch_reg);
                    res_next.last = 1'b1;
                    case (cb_reg.cmd)
                        CMD_PLAY, CMD_REPLAY:
                        begin
                            res_next.action = ACT_START;
                            res_next.out_sound = cb_reg.sound_id;
                            res_next.out_loops = cb_reg.loops;
                            res_next.mixer_vol = prod_reg[33:26];
                        end
                        CMD_VOLUME:
                        begin
                            res_next.action = ACT_VOLUME;
                            res_next.mixer_vol = prod_reg[33:26];
                        end
                        CMD_PAUSE: res_next.action = ACT_PAUSE;
                        CMD_RESUME: res_next.action = ACT_RESUME;
                        default: res_next.action = ACT_HALT;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                rv_next = 1'b1;
                if (rv_reg && !ov_next)
                begin
                    we = 1'b1;
                    waddr = ra_reg[AW-1:0];
                    wdata.busy = 1'b0;
                    wdata.paused = 1'b0;
                    ov_next = 1'b1;
                    res_next = '0;
                    res_next.action = ACT_HALT;
                    res_next.channel = 6'(ra_reg[AW-1:0]);
                    res_next.last = ra_reg[AW-1:0] == LASTCH;
                    ra_next = ra_reg + CW'(1);
                    rv_next = 1'b0;
                    if (ra_reg[AW-1:0] == LASTCH)
                    begin
                        ra_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ra_reg <= '0;
            rc_reg <= '0;
            rv_reg <= 1'b0;
            hit_reg <= 1'b0;
            init_reg <= 1'b1;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ra_reg <= ra_next;
            rc_reg <= rc_next;
            rv_reg <= rv_next;
            hit_reg <= hit_next;
            init_reg <= init_next;
            ov_reg <= ov_next;
        end
    end
    always_ff @(posedge clk)
    begin
        cb_reg <= cb_next;
        ch_reg <= ch_next;
        res_reg <= res_next;
        prod_reg <= prod_next;
    end

    assign res_out.valid = ov_reg;
    assign res_out.data = res_reg;

    a_no_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !cmd_in.ready) else $error("command taken during init");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !res_out.ready |=> ov_reg && $stable(res_reg))
        else $error("result dropped");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_in.ready |-> state_reg == ST_IDLE) else $error("ready while busy");
endmodule
`default_nettype wire

FILE: test/audio_voice_channel_allocator_top_test.sv
`timescale 1ns / 1ps
module audio_voice_channel_allocator_top_test;
    import avca_pkg::*;

    localparam int NCH = 64;
    localparam int CYCLE_LIMIT = 2000000;

    class alloc_scoreboard;
        res_beat_t pending_q[$];
        int errors;
        logic [6:0] master;
        logic [63:0] rsv_mask;
        logic busy[NCH];
        logic paused[NCH];
        logic [63:0] owner[NCH];
        logic [27:0] remain[NCH];

        function new();
            errors = 0;
            master = 100;
            rsv_mask = '0;
            for (int i = 0; i < NCH; i++)
            begin
                busy[i] = 0;
                paused[i] = 0;
                owner[i] = '0;
                remain[i] = '0;
            end
        endfunction

        function logic [7:0] mix_level(logic [6:0] vol);
            int unsigned v;
            int unsigned m;
            v = (vol > 100) ? 100 : vol;
            m = (master > 100) ? 100 : master;
            return 8'((v * m * 128) / 10000);
        endfunction

        function void push_res(action_t a, int ch, logic [15:0] snd, logic [7:0] lp,
                               logic [7:0] mv, logic lst);
            res_beat_t r;
            r.action = a;
            r.channel = 6'(ch);
            r.out_sound = snd;
            r.out_loops = lp;
            r.mixer_vol = mv;
            r.last = lst;
            pending_q.insert(pending_q.size(), r);
        endfunction

        function bit chan_free(int i);
            return !busy[i] && !rsv_mask[i];
        endfunction

        function void note_cmd(cmd_beat_t c);
            int ch;
            int unsigned t;
            ch = -1;
            case (cmd_t'(c.cmd))
                CMD_PLAY, CMD_REPLAY:
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        if (c.cmd == CMD_PLAY)
                        begin
                            if (chan_free(i))
                            begin
                                ch = i;
                                break;
                            end
                        end
                        else
                        begin
                            if (chan_free(i))
                                ch = i;
                            if (owner[i] == c.key)
                            begin
                                ch = i;
                                break;
                            end
                        end
                    end
                    if (ch >= 0)
                    begin
                        paused[ch] = 0;
                        busy[ch] = 1;
                        owner[ch] = c.key;
                        t = c.sound_length * (c.loops + 1);
                        remain[ch] = 28'(t);
                        push_res(ACT_START, ch, c.sound_id, c.loops, mix_level(c.volume), 1);
                    end
                end
                CMD_PAUSE, CMD_RESUME, CMD_HALT, CMD_VOLUME:
                begin
                    for (int i = 0; i < NCH; i++)
                        if (busy[i] && owner[i] == c.key)
                        begin
                            ch = i;
                            break;
                        end
                    if (ch >= 0)
                    begin
                        if (c.cmd == CMD_PAUSE)
                        begin
                            paused[ch] = 1;
                            push_res(ACT_PAUSE, ch, 0, 0, 0, 1);
                        end
                        else if (c.cmd == CMD_RESUME)
                        begin
                            paused[ch] = 0;
                            push_res(ACT_RESUME, ch, 0, 0, 0, 1);
                        end
                        else if (c.cmd == CMD_HALT)
                        begin
                            busy[ch] = 0;
                            paused[ch] = 0;
                            push_res(ACT_HALT, ch, 0, 0, 0, 1);
                        end
                        else
                            push_res(ACT_VOLUME, ch, 0, 0, mix_level(c.volume), 1);
                    end
                end
                CMD_TICK:
                begin
                    for (int i = 0; i < NCH; i++)
                        if (busy[i] && !paused[i])
                        begin
                            remain[i] = (remain[i] > c.elapsed) ? remain[i] - c.elapsed : 0;
                            if (remain[i] == 0)
                            begin
                                busy[i] = 0;
                                paused[i] = 0;
                            end
                        end
                end
                default:
                begin
                    for (int i = 0; i < NCH; i++)
                    begin
                        busy[i] = 0;
                        paused[i] = 0;
                        push_res(ACT_HALT, i, 0, 0, 0, i == NCH - 1);
                    end
                end
            endcase
        endfunction

        function void check_res(res_beat_t got);
            res_beat_t exp_r;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending_q[0];
            pending_q.delete(0);
            if (got.action !== exp_r.action)
                $display("%0t: action exp %0d got %0d", $time, exp_r.action, got.action);
            if (got.channel !== exp_r.channel)
                $display("%0t: channel exp %0d got %0d", $time, exp_r.channel, got.channel);
            if (got.out_sound !== exp_r.out_sound)
                $display("%0t: out_sound exp %0d got %0d", $time, exp_r.out_sound,
                         got.out_sound);
            if (got.out_loops !== exp_r.out_loops)
                $display("%0t: out_loops exp %0d got %0d", $time, exp_r.out_loops,
                         got.out_loops);
            if (got.mixer_vol !== exp_r.mixer_vol)
                $display("%0t: mixer_vol exp %0d got %0d", $time, exp_r.mixer_vol,
                         got.mixer_vol);
            if (got.last !== exp_r.last)
                $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
            if (got !== exp_r)
                errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [3:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    avca_if #(.W($bits(cmd_beat_t))) cmd_ch ();
    avca_if #(.W($bits(res_beat_t))) res_ch ();

    audio_voice_channel_allocator_top u_top (
        .clk(clk), .rst_n(rst_n), .cmd_in(cmd_ch.sink), .res_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    alloc_scoreboard sb = new();
    int cycles = 0;
    bit hold_off = 0;
    logic [63:0] keys[8];

    initial
    begin
        cmd_ch.valid = 0;
        cmd_ch.data = '0;
        res_ch.ready = 0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_res(res_beat_t'(res_ch.data));

    function int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                res_ch.ready <= 0;
            else
            begin
                g = gap_len();
                if (g == 0 || $urandom_range(0, 2) == 0)
                    res_ch.ready <= 1;
                else
                begin
                    res_ch.ready <= 0;
                    repeat (g - 1) @(posedge clk);
                end
            end
        end
    end

    task automatic reg_write(int idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 4'(idx * 8);
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == REG_MASTER)
            sb.master = (val[6:0] > 100) ? 7'd100 : val[6:0];
        else
            sb.rsv_mask = val;
    endtask

    task automatic send_cmd(cmd_beat_t c, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            cmd_ch.valid <= 0;
            repeat (g) @(posedge clk);
        end
        cmd_ch.valid <= 1;
        cmd_ch.data <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        sb.note_cmd(c);
    endtask

    task automatic end_stream();
        cmd_ch.valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (2 * NCH + 20) @(posedge clk);
    endtask

    function cmd_beat_t mk(cmd_t op, logic [63:0] k, logic [15:0] snd, logic [19:0] len,
                           logic [7:0] lp, logic [6:0] vol, logic [15:0] el);
        cmd_beat_t c;
        c.cmd = op;
        c.key = k;
        c.sound_id = snd;
        c.sound_length = len;
        c.loops = lp;
        c.volume = vol;
        c.elapsed = el;
        return c;
    endfunction

    function cmd_beat_t rand_cmd(bit noise);
        cmd_beat_t c;
        int r;
        c.cmd = cmd_t'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 30)
            c.cmd = CMD_PLAY;
        else if (r < 45)
            c.cmd = CMD_REPLAY;
        else if (r < 80)
            c.cmd = cmd_t'($urandom_range(2, 5));
        else if (r < 97)
            c.cmd = CMD_TICK;
        else
            c.cmd = CMD_CLEAR;
        c.key = noise ? {$urandom, $urandom} : keys[$urandom_range(0, 7)];
        c.sound_id = 16'($urandom);
        c.sound_length = ($urandom_range(0, 19) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3000));
        c.loops = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        c.volume = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
        c.elapsed = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        return c;
    endfunction

    initial
    begin
        logic [63:0] kmax;
        kmax = '1;
        for (int i = 0; i < 8; i++)
            keys[i] = {$urandom, $urandom};
        keys[0] = '0;
        keys[1] = kmax;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        repeat (NCH + 5) @(posedge clk);

        reg_write(REG_MASTER, 100);
        reg_write(REG_MASK, 64'h8000_0000_0000_0001);
        send_cmd(mk(CMD_PLAY, kmax, 16'hFFFF, 20'hFFFFF, 8'hFF, 100, 0), 0);
        send_cmd(mk(CMD_PLAY, 64'h5, 0, 0, 0, 0, 0), 0);
        send_cmd(mk(CMD_REPLAY, 64'h0, 1, 10, 1, 50, 0), 0);
        send_cmd(mk(CMD_REPLAY, 64'h1234, 2, 100, 0, 127, 0), 0);
        send_cmd(mk(CMD_REPLAY, kmax, 3, 100, 0, 77, 0), 0);
        send_cmd(mk(CMD_PAUSE, kmax, 0, 0, 0, 0, 0), 0);
        send_cmd(mk(CMD_PAUSE, kmax, 0, 0, 0, 0, 0), 0);
        send_cmd(mk(CMD_VOLUME, kmax, 0, 0, 0, 33, 0), 0);
        send_cmd(mk(CMD_VOLUME, 64'h999, 0, 0, 0, 33, 0), 0);
        send_cmd(mk(CMD_TICK, 0, 0, 0, 0, 0, 0), 0);
        send_cmd(mk(CMD_TICK, 0, 0, 0, 0, 0, 16'hFFFF), 0);
        send_cmd(mk(CMD_RESUME, kmax, 0, 0, 0, 0, 0), 0);
        send_cmd(mk(CMD_HALT, 64'h1234, 0, 0, 0, 0, 0), 0);
        send_cmd(mk(CMD_HALT, 64'h1234, 0, 0, 0, 0, 0), 0);
        send_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0);
        end_stream();
        drain();

        reg_write(REG_MASK, kmax);
        reg_write(REG_MASTER, 0);
        send_cmd(mk(CMD_PLAY, 1, 1, 1, 1, 100, 0), 0);
        send_cmd(mk(CMD_REPLAY, 64'h77, 1, 1, 1, 100, 0), 0);
        send_cmd(mk(CMD_REPLAY, 64'h0, 9, 1, 1, 100, 0), 0);
        end_stream();
        drain();

        reg_write(REG_MASK, 64'h0);
        reg_write(REG_MASTER, 127);
        for (int i = 0; i < 70; i++)
            send_cmd(mk(CMD_PLAY, 64'(i), 16'(i), 1000, 0, 100, 0), 0);
        send_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0);
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++)
                send_cmd(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0);
        join
        end_stream();
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            reg_write(REG_MASTER, 7'($urandom_range(0, 127)));
            reg_write(REG_MASK, ph == 0 ? 64'h0 : {$urandom, $urandom} & {$urandom, $urandom});
            for (int n = 0; n < 30; n++)
                send_cmd(rand_cmd($urandom_range(0, 9) == 0), 1);
            end_stream();
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: files.f
sv/avca_pkg.sv
sv/avca_if.sv
sv/avca_table.sv
sv/audio_voice_channel_allocator_top.sv
test/audio_voice_channel_allocator_top_test.sv
